/* rtl/command_frame_deframer_assert.svh */
// Assertion macros used by the deframer core.
`ifndef COMMAND_FRAME_DEFRAMER_ASSERT_SVH
`define COMMAND_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, checked outside reset.
`define CFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

/* rtl/cfd_pkg.sv */
package cfd_pkg;

    localparam int ByteW  = 8;
    localparam int RoleW  = 3;
    localparam int StatW  = 2;
    localparam int PhaseW = 3;

    // Shortest legal length byte: type and register bytes plus the length itself.
    localparam logic [ByteW-1:0] MinLen = 8'd3;

    typedef enum logic [PhaseW-1:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_REG  = 3'd3,
        PH_PAY  = 3'd4,
        PH_SUM  = 3'd5
    } t_phase;

    typedef enum logic [RoleW-1:0] {
        ROLE_CMD     = 3'd0,
        ROLE_LEN     = 3'd1,
        ROLE_TYPE    = 3'd2,
        ROLE_REG     = 3'd3,
        ROLE_PAY     = 3'd4,
        ROLE_SUM     = 3'd5,
        ROLE_DISCARD = 3'd6
    } t_role;

    typedef enum logic [StatW-1:0] {
        ST_OK     = 2'd0,
        ST_BADCMD = 2'd1,
        ST_BADLEN = 2'd2,
        ST_TRUNC  = 2'd3
    } t_status;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             eob;
    } t_item;

    typedef struct packed {
        logic [ByteW-1:0] byte_value;
        t_role            role;
        logic [ByteW-1:0] payload_index;
        t_status          status;
        logic             checksum_ok;
        logic             frame_end;
    } t_result;

    function automatic logic is_command(input logic [ByteW-1:0] b);
        logic hit;
        case (b)
            8'hf2, 8'h2f, 8'hf6, 8'h6f, 8'hf9, 8'h9f: hit = 1'b1;
            default:                                 hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

/* rtl/cfd_in_stage.sv */
module cfd_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cfd_pkg::t_item i_item,
    output logic          o_valid,
    input  logic          i_take,
    output cfd_pkg::t_item o_item
);
    import cfd_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  n_valid;

    // The stage refills in the same cycle the core drains it.
    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/cfd_core.sv */
module cfd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  cfd_pkg::t_item   i_item,
    output logic             o_take,
    output logic             o_valid,
    input  logic             i_ready,
    output cfd_pkg::t_result o_result
);
    import cfd_pkg::*;

    t_phase           r_phase, n_phase;
    logic [ByteW-1:0] r_len, n_len;
    logic [ByteW-1:0] r_cnt, n_cnt;
    logic [ByteW-1:0] r_sum, n_sum;
    logic             r_out_valid;
    t_result          r_res, n_res;

    logic [ByteW-1:0] cnt_inc;
    logic [ByteW-1:0] sum_add;
    logic             can_trunc;

    assign o_take  = i_valid && (!r_out_valid || i_ready);
    assign cnt_inc = r_cnt + 8'd1;
    assign sum_add = r_sum + i_item.data;

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        can_trunc = 1'b1;
        n_res.byte_value    = i_item.data;
        n_res.role          = ROLE_DISCARD;
        n_res.payload_index = '0;
        n_res.status        = ST_OK;
        n_res.checksum_ok   = 1'b0;
        n_res.frame_end     = 1'b0;

        unique case (r_phase)
            PH_LEN: begin
                n_res.role = ROLE_LEN;
                if (i_item.data < MinLen) begin
                    n_res.status    = ST_BADLEN;
                    n_res.frame_end = 1'b1;
                    can_trunc       = 1'b0;
                    n_phase         = PH_HUNT;
                end else begin
                    n_len   = i_item.data;
                    n_sum   = sum_add;
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_res.role = ROLE_TYPE;
                n_sum      = sum_add;
                n_phase    = PH_REG;
            end
            PH_REG: begin
                n_res.role = ROLE_REG;
                n_sum      = sum_add;
                n_cnt      = '0;
                n_phase    = (r_len <= MinLen) ? PH_SUM : PH_PAY;
            end
            PH_PAY: begin
                n_res.role          = ROLE_PAY;
                n_res.payload_index = r_cnt;
                n_sum               = sum_add;
                n_cnt               = cnt_inc;
                if ({1'b0, cnt_inc} + {1'b0, MinLen} >= {1'b0, r_len}) begin
                    n_phase = PH_SUM;
                end
            end
            PH_SUM: begin
                n_res.role        = ROLE_SUM;
                n_res.checksum_ok = (i_item.data == r_sum);
                n_res.frame_end   = 1'b1;
                can_trunc         = 1'b0;
                n_phase           = PH_HUNT;
            end
            default: begin
                // Hunting; unused phase codes also land here.
                if (is_command(i_item.data)) begin
                    n_res.role = ROLE_CMD;
                    n_sum      = i_item.data;
                    n_len      = '0;
                    n_cnt      = '0;
                    n_phase    = PH_LEN;
                end else begin
                    n_res.status = ST_BADCMD;
                    can_trunc    = 1'b0;
                    n_phase      = PH_HUNT;
                end
            end
        endcase

        if (i_item.eob && can_trunc) begin
            n_res.status    = ST_TRUNC;
            n_res.frame_end = 1'b1;
            n_phase         = PH_HUNT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_len       <= '0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase <= n_phase;
                r_len   <= n_len;
                r_cnt   <= n_cnt;
                r_sum   <= n_sum;
            end
            r_out_valid <= o_take || (r_out_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_res;

`include "command_frame_deframer_assert.svh"

    `CFD_ASSERT_IMP(a_ck_only_on_sum, i_clk, i_rst_n, r_out_valid && r_res.checksum_ok, r_res.role == ROLE_SUM)
    `CFD_ASSERT_IMP(a_discard_badcmd, i_clk, i_rst_n, r_out_valid && r_res.role == ROLE_DISCARD, r_res.status == ST_BADCMD && !r_res.frame_end)
    `CFD_ASSERT_IMP(a_ok_end_is_sum, i_clk, i_rst_n, r_out_valid && r_res.frame_end && r_res.status == ST_OK, r_res.role == ROLE_SUM)
    `CFD_ASSERT_NXT(a_end_back_to_hunt, i_clk, i_rst_n, o_take && n_res.frame_end, r_phase == PH_HUNT)
    `CFD_ASSERT_IMP(a_pay_count_bound, i_clk, i_rst_n, r_phase == PH_PAY, {1'b0, r_cnt} + {1'b0, MinLen} < {1'b0, r_len})

endmodule

/* rtl/command_frame_deframer.sv */
// Command frame deframer: takes one received byte per transaction and returns one result
// per byte giving its role in the frame (command, length, type, register, payload,
// checksum or discarded), its payload index, a status code and the checksum verdict.
// A new byte is accepted every clock cycle while the output side keeps taking results;
// each byte is held in the input stage register and then in the core's result register
// before its result can be taken. The rate is set by the single frame-state update
// in the core stage, which handles one byte per cycle, and both the input register and
// the result register refill in the cycle they are drained.
module command_frame_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_buffer,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte_value,
    output logic [2:0] o_role,
    output logic [7:0] o_payload_index,
    output logic [1:0] o_status,
    output logic       o_checksum_ok,
    output logic       o_frame_end
);
    import cfd_pkg::*;

    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    core_take;
    t_result result;

    assign in_item.data = i_in_byte;
    assign in_item.eob  = i_end_of_buffer;

    cfd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .i_take  (core_take),
        .o_item  (stage_item)
    );

    cfd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stage_valid),
        .i_item   (stage_item),
        .o_take   (core_take),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result)
    );

    assign o_byte_value    = result.byte_value;
    assign o_role          = result.role;
    assign o_payload_index = result.payload_index;
    assign o_status        = result.status;
    assign o_checksum_ok   = result.checksum_ok;
    assign o_frame_end     = result.frame_end;

endmodule
